### src/bgpu_pkg.sv
// ----------------------------------------------------------------------------
// bgpu_pkg
// Shared types, constants and the bar-top pattern function for the bar graph
// page update block.
// ----------------------------------------------------------------------------
package bgpu_pkg;

    // display geometry
    localparam int unsigned PAGE_ROWS  = 8;
    localparam int unsigned BAR_MAX    = 64;

    localparam int unsigned COL_W      = 7;
    localparam int unsigned HGT_W      = 8;
    localparam int unsigned CLAMP_W    = 7;   // clamped height 1..64
    localparam int unsigned SPAN_W     = 7;   // pixel span 0..64
    localparam int unsigned PAGE_W     = 3;
    localparam int unsigned PAT_W      = 8;

    localparam logic [PAT_W-1:0] PAT_FILL  = 8'hFF;
    localparam logic [PAT_W-1:0] PAT_CLEAR = 8'h00;

    // input request
    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [HGT_W-1:0] new_height;
        logic [HGT_W-1:0] old_height;
    } t_in_req;

    // one page write
    typedef struct packed {
        logic [COL_W-1:0]  write_column;
        logic [PAGE_W-1:0] page;
        logic [PAT_W-1:0]  pattern;
        logic              last;
    } t_out_req;

    // job handed from setup logic to the sequencer
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [SPAN_W-1:0] span;
        logic [PAGE_W-1:0] page;
        logic              grow;
        logic              skip;   // heights equal, nothing to write
    } t_job;

    // bar-top pattern: k lowest pixels set, bit 7 is the bottom pixel
    function automatic logic [PAT_W-1:0] bar_top(input logic [2:0] k);
        logic [PAT_W-1:0] p;
        case (k)
            3'd0:    p = 8'h00;
            3'd1:    p = 8'h80;
            3'd2:    p = 8'hC0;
            3'd3:    p = 8'hE0;
            3'd4:    p = 8'hF0;
            3'd5:    p = 8'hF8;
            3'd6:    p = 8'hFC;
            3'd7:    p = 8'hFE;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

### src/bar_graph_page_update_core.sv
// ----------------------------------------------------------------------------
// bar_graph_page_update_core
// Turns a bar's old height into its new height with the fewest page writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one request:
//   column, new height and old height. Heights saturate at 64, zero counts
//   as one. Output channel (o_out_valid / i_out_stall / o_out_data) gives
//   0 to 8 page writes per request, the final one flagged by last.
//   A taken request is loaded into the sequencer; its writes then pass
//   through the output register, one write per cycle while the receiver
//   does not stall. The single span-stepping sequencer holds o_in_stall
//   until the last write is loaded, so no new request is taken earlier;
//   equal heights produce nothing and do not raise o_in_stall.
//   A new request is taken while the last write still waits in the output
//   register. A receiver stall holds the write in place and pauses the
//   sequencer. Synchronous reset drops any update in flight and empties
//   the output register.
// ----------------------------------------------------------------------------
module bar_graph_page_update_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bgpu_pkg::t_in_req  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bgpu_pkg::t_out_req o_out_data
);
    import bgpu_pkg::*;

    t_job job;
    logic busy;

    // clamp and span setup
    bgpu_setup u_setup (
        .i_req (i_in_data),
        .o_job (job)
    );

    // page write sequencer
    bgpu_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && !busy),
        .i_job       (job),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    assign o_in_stall = busy;

endmodule

### src/bgpu_setup.sv
// ----------------------------------------------------------------------------
// bgpu_setup
// Clamps both heights and works out the pixel span, the starting page and
// the direction of one bar update, and flags equal heights.
// ----------------------------------------------------------------------------
module bgpu_setup (
    input  bgpu_pkg::t_in_req i_req,
    output bgpu_pkg::t_job    o_job
);
    import bgpu_pkg::*;

    logic [CLAMP_W-1:0] hn;
    logic [CLAMP_W-1:0] ho;
    logic [HGT_W-1:0]   hn_up;
    logic [HGT_W-1:0]   ho_up;
    logic [HGT_W-1:0]   span_w;
    logic [PAGE_W-1:0]  pg0;
    logic [PAGE_W-1:0]  pg_start;
    logic               grow;

    // saturate to 64, zero counts as one
    always_comb begin
        if (i_req.new_height > HGT_W'(BAR_MAX)) begin
            hn = CLAMP_W'(BAR_MAX);
        end else if (i_req.new_height == '0) begin
            hn = CLAMP_W'(1);
        end else begin
            hn = i_req.new_height[CLAMP_W-1:0];
        end
        if (i_req.old_height > HGT_W'(BAR_MAX)) begin
            ho = CLAMP_W'(BAR_MAX);
        end else if (i_req.old_height == '0) begin
            ho = CLAMP_W'(1);
        end else begin
            ho = i_req.old_height[CLAMP_W-1:0];
        end
    end

    // heights rounded up to the next page boundary
    assign hn_up = {1'b0, hn[6:3] + 4'd1, 3'b000};
    assign ho_up = {1'b0, ho[6:3] + 4'd1, 3'b000};
    assign grow  = hn > ho;
    // page holding the pixel just above the old top, kept modulo 8
    assign pg0   = PAGE_W'(4'd7 - ho[6:3]);

    // span in pixels and start page
    always_comb begin
        pg_start = pg0;
        if (grow) begin
            span_w = {1'b0, hn} - {1'b0, ho[6:3], 3'b000};
        end else if (ho[2:0] == 3'd0) begin
            if (hn[2:0] == 3'd0) begin
                span_w = {1'b0, ho} - {1'b0, hn};
            end else begin
                span_w = {1'b0, ho} - hn_up + {5'd0, hn[2:0]};
            end
            pg_start = pg0 + 3'd1;
        end else begin
            if (hn[2:0] == 3'd0) begin
                span_w = ho_up - {1'b0, hn};
            end else begin
                span_w = ho_up - hn_up + {5'd0, hn[2:0]};
            end
        end
    end

    assign o_job.col  = i_req.column;
    assign o_job.span = span_w[SPAN_W-1:0];
    assign o_job.page = pg_start;
    assign o_job.grow = grow;
    assign o_job.skip = (hn == ho);

endmodule

### src/bgpu_seq.sv
// ----------------------------------------------------------------------------
// bgpu_seq
// Page write sequencer: one shared subtract-by-a-page unit walks the span,
// emitting one page write per step into the output register.
// ----------------------------------------------------------------------------
module bgpu_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  bgpu_pkg::t_job     i_job,
    output logic               o_busy,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bgpu_pkg::t_out_req o_out_data
);
    import bgpu_pkg::*;

    typedef enum logic [0:0] {S_IDLE, S_RUN} t_state;

    t_state             r_state;
    logic [COL_W-1:0]   r_col;
    logic [SPAN_W-1:0]  r_span;
    logic [PAGE_W-1:0]  r_page;
    logic               r_grow;
    logic               r_out_valid;
    t_out_req           r_out;

    logic [SPAN_W-1:0]  n_span;
    logic               full;
    logic               emit;
    t_out_req           n_out;

    // shared step unit: take one page off the span
    assign n_span = r_span - SPAN_W'(PAGE_ROWS);
    assign full   = (r_span[SPAN_W-1:3] != '0);
    assign emit   = (r_state == S_RUN) && (!r_out_valid || !i_out_stall);

    // page write for this step
    always_comb begin
        n_out.write_column = r_col;
        n_out.page         = r_page;
        if (full) begin
            n_out.pattern = r_grow ? PAT_FILL : PAT_CLEAR;
            n_out.last    = (n_span == '0);
        end else begin
            n_out.pattern = bar_top(r_span[2:0]);
            n_out.last    = 1'b1;
        end
    end

    // sequencer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start && !i_job.skip) begin
                        r_state <= S_RUN;
                        r_col   <= i_job.col;
                        r_span  <= i_job.span;
                        r_page  <= i_job.page;
                        r_grow  <= i_job.grow;
                    end
                end
                S_RUN: begin
                    if (emit) begin
                        r_span <= n_span;
                        r_page <= r_grow ? r_page - 3'd1 : r_page + 3'd1;
                        if (n_out.last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (emit) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_busy      = (r_state == S_RUN);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### src/bgpu_checker.sv
// ----------------------------------------------------------------------------
// bgpu_checker
// Port-level checks for the bar graph page update block, bound to the top.
// ----------------------------------------------------------------------------
module bgpu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input bgpu_pkg::t_in_req  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input bgpu_pkg::t_out_req o_out_data
);
    import bgpu_pkg::*;

    // stalled request holds at the input
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled bar request changed");

    // stalled write holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled page write changed");

    // the block is free right after reset
    a_rst_free: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("busy after reset");

    // an update ends only with its last write loaded
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid && o_out_data.last)
        else $error("update ended without last write");

    // writes of one update follow back to back on the same column
    a_same_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.last
        |=> o_out_valid
            && o_out_data.write_column == $past(o_out_data.write_column))
        else $error("update broken or column changed");

endmodule

bind bar_graph_page_update_core bgpu_checker u_bgpu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
